>>> rtl/vipf_pkg.sv
// Shared types and constants of the source prefix filter.
package vipf_pkg;

    localparam int unsigned RULE_ENTRIES_DEF = 1024;
    localparam int unsigned IDX_W            = 10;
    localparam int unsigned META_W           = 13;
    localparam int unsigned DIN_W            = 160;
    localparam int unsigned DOUT_W           = 8;

    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_QINQ  = 16'h88A8;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    localparam logic [2:0] ACT_ABORTED = 3'd0;
    localparam logic [2:0] ACT_PASS    = 3'd2;
    localparam logic [2:0] ACT_MAX     = 3'd4;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_TAG,
        PH_IP4,
        PH_IP6,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] upper;
        logic [63:0] lower;
    } query_t;

    typedef struct packed {
        logic             vld;
        logic             is_wr;
        logic [IDX_W-1:0] idx;
        logic             r_valid;
        logic             r_v6;
        logic [7:0]       r_plen;
        logic [2:0]       r_act;
        logic [63:0]      upper;
        logic [63:0]      lower;
        logic [1:0]       family;
        logic             found;
        logic [7:0]       best_len;
        logic [2:0]       best_act;
    } tok_t;

endpackage

>>> rtl/vipf_parser.sv
// Header parser: tracks tags and captures the IPv4 or IPv6 source address.
module vipf_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_en,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output vipf_pkg::query_t query
);
    import vipf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] etype_reg, etype_next;
    logic [1:0]  tags_reg, tags_next;
    logic [4:0]  ihs_reg, ihs_next;
    logic [1:0]  fam_reg, fam_next;
    logic [63:0] su_reg, su_next;
    logic [63:0] sl_reg, sl_next;

    logic [15:0] etype_sh;
    logic [15:0] rel;
    logic [16:0] off_p1;
    logic [16:0] off_p2;
    logic        is_tag;

    assign etype_sh = {etype_reg[7:0], data_byte};
    assign rel      = off_reg - {11'd0, ihs_reg};
    assign off_p1   = {1'b0, off_reg} + 17'd1;
    assign off_p2   = {1'b0, off_reg} + 17'd2;
    assign is_tag   = (etype_sh == ETH_VLAN) || (etype_sh == ETH_QINQ);

    always_comb
    begin
        phase_next = phase_reg;
        etype_next = etype_reg;
        tags_next  = tags_reg;
        ihs_next   = ihs_reg;
        fam_next   = fam_reg;
        su_next    = su_reg;
        sl_next    = sl_reg;
        off_next   = (off_reg != 16'hFFFF) ? off_reg + 16'd1 : off_reg;
        if (byte_en)
        begin
            case (phase_reg)
                PH_ETH, PH_TAG:
                begin
                    if ((phase_reg == PH_ETH && (off_reg == 16'd12 || off_reg == 16'd13)) ||
                        (phase_reg == PH_TAG && (off_p2 == {12'd0, ihs_reg} ||
                                                 off_p1 == {12'd0, ihs_reg})))
                    begin
                        etype_next = etype_sh;
                    end
                    if ((phase_reg == PH_ETH && off_reg == 16'd13) ||
                        (phase_reg == PH_TAG && off_p1 == {12'd0, ihs_reg}))
                    begin
                        if (is_tag && tags_reg < 2'd2)
                        begin
                            tags_next  = tags_reg + 2'd1;
                            ihs_next   = ihs_reg + 5'd4;
                            phase_next = PH_TAG;
                        end
                        else if (etype_sh == ETH_IPV4)
                        begin
                            phase_next = PH_IP4;
                        end
                        else if (etype_sh == ETH_IPV6)
                        begin
                            phase_next = PH_IP6;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_IP4:
                begin
                    if (rel >= 16'd12 && rel <= 16'd15)
                    begin
                        sl_next = {32'd0, sl_reg[23:0], data_byte};
                    end
                    if (rel == 16'd19)
                    begin
                        fam_next   = FAM_V4;
                        phase_next = PH_DONE;
                    end
                end
                PH_IP6:
                begin
                    if (rel >= 16'd8 && rel <= 16'd15)
                    begin
                        su_next = {su_reg[55:0], data_byte};
                    end
                    if (rel >= 16'd16 && rel <= 16'd23)
                    begin
                        sl_next = {sl_reg[55:0], data_byte};
                    end
                    if (rel == 16'd39)
                    begin
                        fam_next   = FAM_V6;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            off_next = off_reg;
        end
    end

    always_comb
    begin
        query.family = fam_next;
        query.upper  = su_next;
        query.lower  = sl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ETH;
            off_reg   <= '0;
            etype_reg <= '0;
            tags_reg  <= '0;
            ihs_reg   <= 5'd14;
            fam_reg   <= FAM_NONE;
            su_reg    <= '0;
            sl_reg    <= '0;
        end
        else if (byte_en && last_byte)
        begin
            phase_reg <= PH_ETH;
            off_reg   <= '0;
            etype_reg <= '0;
            tags_reg  <= '0;
            ihs_reg   <= 5'd14;
            fam_reg   <= FAM_NONE;
            su_reg    <= '0;
            sl_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            etype_reg <= etype_next;
            tags_reg  <= tags_next;
            ihs_reg   <= ihs_next;
            fam_reg   <= fam_next;
            su_reg    <= su_next;
            sl_reg    <= sl_next;
        end
    end

endmodule

>>> rtl/vipf_cell.sv
// One rule cell: holds a rule, applies writes and updates the passing best match.
module vipf_cell
#(
    parameter int unsigned CELL_ID = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  vipf_pkg::tok_t tok_in,
    output vipf_pkg::tok_t tok_out
);
    import vipf_pkg::*;

    localparam logic ADDRESSABLE = (CELL_ID < (2 ** IDX_W));
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic        valid_reg;
    logic        v6_reg;
    logic [7:0]  plen_reg;
    logic [2:0]  act_reg;
    logic [63:0] up_reg;
    logic [63:0] lo_reg;

    tok_t         tok_reg, tok_next;
    logic         wr_hit;
    logic [7:0]   plen_c;
    logic [127:0] mask6;
    logic [31:0]  mask4;
    logic         hit;

    assign wr_hit = ADDRESSABLE && tok_in.vld && tok_in.is_wr && (tok_in.idx == MY_IDX);

    always_comb
    begin
        if (v6_reg)
        begin
            plen_c = (plen_reg > 8'd128) ? 8'd128 : plen_reg;
        end
        else
        begin
            plen_c = (plen_reg > 8'd32) ? 8'd32 : plen_reg;
        end
        mask6 = ~({128{1'b1}} >> plen_c);
        mask4 = ~({32{1'b1}} >> plen_c[5:0]);
        if (!tok_in.vld || tok_in.is_wr || !valid_reg)
        begin
            hit = 1'b0;
        end
        else if (tok_in.family == FAM_V6)
        begin
            hit = v6_reg &&
                  ((({tok_in.upper, tok_in.lower} ^ {up_reg, lo_reg}) & mask6) == '0);
        end
        else if (tok_in.family == FAM_V4)
        begin
            hit = !v6_reg && (((tok_in.lower[31:0] ^ lo_reg[31:0]) & mask4) == '0);
        end
        else
        begin
            hit = 1'b0;
        end
        tok_next = tok_in;
        if (hit && (!tok_in.found || plen_c > tok_in.best_len))
        begin
            tok_next.found    = 1'b1;
            tok_next.best_len = plen_c;
            tok_next.best_act = act_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
            if (wr_hit)
            begin
                valid_reg <= tok_in.r_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && wr_hit)
        begin
            v6_reg   <= tok_in.r_v6;
            plen_reg <= tok_in.r_plen;
            act_reg  <= tok_in.r_act;
            up_reg   <= tok_in.upper;
            lo_reg   <= tok_in.lower;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/vlan_ip_source_prefix_filter_core.sv
// Top level of the VLAN-aware IP source longest-prefix filter.
//  channel  | dir | tdata                              | tuser | tlast
//  s_axis   | in  | packet bytes and rule writes       | func  | last_byte
//  m_axis   | out | one verdict per packet             | -     | -
// One input transaction per cycle while m_axis is not stalled, bytes and rule writes alike.
// A verdict passes every rule cell register and then the output register: the query walks
// one rule cell per cycle down the chain while m_axis is not stalled, writes walk the same way behind it.
// Reset clears all rule valid bits at once; no clearing sweep follows.
// A stalled m_axis freezes the whole chain and holds s_axis_tready low.
module vlan_ip_source_prefix_filter_core
#(
    parameter int unsigned RULE_ENTRIES = vipf_pkg::RULE_ENTRIES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // data_byte[7:0], rule_index[17:8], rule_valid[18], rule_is_v6[19],
    // rule_prefix_len[27:20], rule_addr_upper[91:28], rule_addr_lower[155:92],
    // rule_action[158:156], zero[159]
    input  logic [vipf_pkg::DIN_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tlast,
    // func[0]
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // verdict[2:0], packet_family[4:3], rule_matched[5], zero[7:6]
    output logic [vipf_pkg::DOUT_W-1:0] m_axis_tdata
);
    import vipf_pkg::*;

    logic   adv;
    logic   accept;
    logic   byte_en;
    query_t query;
    tok_t   chain [0:RULE_ENTRIES];

    logic               m_vld_reg, m_vld_next;
    logic [DOUT_W-1:0]  m_data_reg, m_data_next;
    logic [2:0]         verdict;

    assign adv           = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign byte_en       = accept && (s_axis_tuser == FUNC_BYTE);

    vipf_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (s_axis_tdata[7:0]),
        .last_byte (s_axis_tlast),
        .query     (query)
    );

    always_comb
    begin
        chain[0]          = '0;
        chain[0].vld      = accept && ((s_axis_tuser == FUNC_WRITE) || s_axis_tlast);
        chain[0].is_wr    = (s_axis_tuser == FUNC_WRITE);
        chain[0].idx      = s_axis_tdata[17:8];
        chain[0].r_valid  = s_axis_tdata[18];
        chain[0].r_v6     = s_axis_tdata[19];
        chain[0].r_plen   = s_axis_tdata[27:20];
        chain[0].r_act    = s_axis_tdata[158:156];
        chain[0].best_act = ACT_PASS;
        if (s_axis_tuser == FUNC_WRITE)
        begin
            chain[0].upper = s_axis_tdata[91:28];
            chain[0].lower = s_axis_tdata[155:92];
        end
        else
        begin
            chain[0].upper  = query.upper;
            chain[0].lower  = query.lower;
            chain[0].family = query.family;
        end
    end

    for (genvar i = 0; i < RULE_ENTRIES; i++)
    begin : g_cell
        vipf_cell #(.CELL_ID(i)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    always_comb
    begin
        verdict     = (chain[RULE_ENTRIES].best_act > ACT_MAX) ? ACT_ABORTED
                                                               : chain[RULE_ENTRIES].best_act;
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        if (adv)
        begin
            m_vld_next  = chain[RULE_ENTRIES].vld && !chain[RULE_ENTRIES].is_wr;
            m_data_next = {2'b00, chain[RULE_ENTRIES].found,
                           chain[RULE_ENTRIES].family, verdict};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain[RULE_ENTRIES]))
        else $error("chain moved while output stalled");
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ACT_MAX)
        else $error("verdict out of range");
    a_match_family: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[4:3] != FAM_NONE)
        else $error("match reported without IP family");
    a_nomatch_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[5]) |-> m_axis_tdata[2:0] == ACT_PASS)
        else $error("unmatched packet not passed");
`endif

endmodule

>>> tb/sv/tb_vlan_ip_source_prefix_filter_core.sv
// Testbench of the VLAN-aware IP source prefix filter: streams rule writes and packets, predicts
// each verdict and checks the result stream.
module tb_vlan_ip_source_prefix_filter_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vipf_pkg::*;

    class verdict_board;
        typedef struct {
            logic [2:0] verdict;
            logic [1:0] family;
            logic       matched;
        } verdict_t;

        logic [META_W-1:0] meta [RULE_ENTRIES_DEF];
        logic [63:0]       pfx_hi [RULE_ENTRIES_DEF];
        logic [63:0]       pfx_lo [RULE_ENTRIES_DEF];
        int unsigned       offset;
        phase_t            phase;
        logic [15:0]       etype;
        int unsigned       tags;
        int unsigned       hdr_start;
        logic [1:0]        family;
        logic [63:0]       src_hi;
        logic [63:0]       src_lo;
        verdict_t          pending [$];
        int                errors;
        int                verdicts_seen;

        function new();
            foreach (meta[i]) meta[i] = '0;
            errors = 0;
            verdicts_seen = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            offset = 0;
            phase = PH_ETH;
            etype = '0;
            tags = 0;
            hdr_start = 14;
            family = FAM_NONE;
            src_hi = '0;
            src_lo = '0;
        endfunction

        function void dispatch();
            if ((etype == ETH_VLAN || etype == ETH_QINQ) && tags < 2)
            begin
                tags++;
                hdr_start += 4;
                phase = PH_TAG;
            end
            else if (etype == ETH_IPV4)
                phase = PH_IP4;
            else if (etype == ETH_IPV6)
                phase = PH_IP6;
            else
                phase = PH_DONE;
        endfunction

        function verdict_t search();
            verdict_t    v;
            logic [127:0] msk;
            logic [31:0]  m4;
            int unsigned  plen;
            int unsigned  best_len;
            logic [2:0]   best_act;
            bit           found;
            bit           hit;
            bit           want_v6;
            found = 0;
            best_len = 0;
            best_act = ACT_PASS;
            want_v6 = (family == FAM_V6);
            if (family == FAM_V4 || family == FAM_V6)
            begin
                for (int i = 0; i < RULE_ENTRIES_DEF; i++)
                begin
                    if (!meta[i][12] || meta[i][11] != want_v6)
                        continue;
                    plen = meta[i][10:3];
                    if (want_v6)
                    begin
                        if (plen > 128) plen = 128;
                        msk = (plen == 0) ? '0 : ~128'd0 << (128 - plen);
                        hit = ((({src_hi, src_lo} ^ {pfx_hi[i], pfx_lo[i]}) & msk) == 0);
                    end
                    else
                    begin
                        if (plen > 32) plen = 32;
                        m4 = (plen == 0) ? '0 : ~32'd0 << (32 - plen);
                        hit = (((src_lo[31:0] ^ pfx_lo[i][31:0]) & m4) == 0);
                    end
                    if (hit && (!found || plen > best_len))
                    begin
                        found = 1;
                        best_len = plen;
                        best_act = meta[i][2:0];
                    end
                end
            end
            v.verdict = (best_act > ACT_MAX) ? ACT_ABORTED : best_act;
            v.family = family;
            v.matched = found;
            return v;
        endfunction

        function void note(bit func, logic [DIN_W-1:0] d, bit last);
            logic [7:0]  b;
            int unsigned rel;
            if (func == FUNC_WRITE)
            begin
                meta[d[17:8]] = {d[18], d[19], d[27:20], d[158:156]};
                pfx_hi[d[17:8]] = d[91:28];
                pfx_lo[d[17:8]] = d[155:92];
                return;
            end
            b = d[7:0];
            rel = offset - hdr_start;
            case (phase)
                PH_ETH:
                begin
                    if (offset == 12 || offset == 13) etype = {etype[7:0], b};
                    if (offset == 13) dispatch();
                end
                PH_TAG:
                begin
                    if (offset + 2 == hdr_start || offset + 1 == hdr_start)
                        etype = {etype[7:0], b};
                    if (offset + 1 == hdr_start) dispatch();
                end
                PH_IP4:
                begin
                    if (rel >= 12 && rel <= 15) src_lo = {32'd0, src_lo[23:0], b};
                    if (rel == 19)
                    begin
                        family = FAM_V4;
                        phase = PH_DONE;
                    end
                end
                PH_IP6:
                begin
                    if (rel >= 8 && rel <= 15) src_hi = {src_hi[55:0], b};
                    if (rel >= 16 && rel <= 23) src_lo = {src_lo[55:0], b};
                    if (rel == 39)
                    begin
                        family = FAM_V6;
                        phase = PH_DONE;
                    end
                end
                default: ;
            endcase
            if (offset < 16'hFFFF) offset++;
            if (last)
            begin
                pending.push_back(search());
                clear_parser();
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic [DOUT_W-1:0] t);
            verdict_t e;
            verdicts_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected verdict %h", t));
                return;
            end
            e = pending.pop_front();
            if (t[2:0] !== e.verdict || t[4:3] !== e.family || t[5] !== e.matched)
                report($sformatf("verdict #%0d got v%0d f%0d m%0d, want v%0d f%0d m%0d",
                    verdicts_seen, t[2:0], t[4:3], t[5], e.verdict, e.family, e.matched));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DIN_W-1:0]  s_axis_tdata;
    logic              s_axis_tlast;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DOUT_W-1:0] m_axis_tdata;

    verdict_board board;
    bit               hold_req;
    bit               quiet;
    int               items_sent;
    logic [127:0]     pool4 [$];
    logic [127:0]     pool6 [$];

    vlan_ip_source_prefix_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(bit func, logic [DIN_W-1:0] d, bit last);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        board.note(func, d, last);
        items_sent++;
    endtask

    task automatic write_rule(int idx, bit valid, bit v6, int plen, logic [63:0] hi,
                              logic [63:0] lo, int act);
        logic [DIN_W-1:0] d;
        d = '0;
        d[7:0] = 8'($urandom);
        d[17:8] = IDX_W'(idx);
        d[18] = valid;
        d[19] = v6;
        d[27:20] = 8'(plen);
        d[91:28] = hi;
        d[155:92] = lo;
        d[158:156] = 3'(act);
        if (v6) pool6.push_back({hi, lo});
        else pool4.push_back({64'd0, lo});
        send_item(FUNC_WRITE, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic rand_rule();
        bit v6;
        int plen;
        v6 = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, 255);
        else plen = v6 ? $urandom_range(0, 128) : $urandom_range(0, 32);
        write_rule(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15),
                   $urandom_range(0, 5) != 0, v6, plen, rand64(), rand64(),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
    endtask

    // ntags tag headers, then etype, an IP header when it is an IP type, extra payload;
    // cut > 0 keeps only that many bytes
    task automatic send_packet(int ntags, logic [15:0] etype, logic [127:0] src, int extra,
                               int cut);
        logic [7:0] pkt [$];
        int         hlen;
        for (int i = 0; i < 12; i++) pkt.push_back(8'($urandom));
        for (int t = 0; t < ntags; t++)
        begin
            logic [15:0] tt;
            tt = $urandom_range(0, 1) ? ETH_VLAN : ETH_QINQ;
            pkt.push_back(tt[15:8]);
            pkt.push_back(tt[7:0]);
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
        end
        pkt.push_back(etype[15:8]);
        pkt.push_back(etype[7:0]);
        hlen = (etype == ETH_IPV4) ? 20 : (etype == ETH_IPV6) ? 40 : 0;
        for (int i = 0; i < hlen; i++)
        begin
            if (etype == ETH_IPV4 && i >= 12 && i <= 15)
                pkt.push_back(src[8 * (15 - i) +: 8]);
            else if (etype == ETH_IPV6 && i >= 8 && i <= 23)
                pkt.push_back(src[8 * (23 - i) +: 8]);
            else
                pkt.push_back(8'($urandom));
        end
        for (int i = 0; i < extra; i++) pkt.push_back(8'($urandom));
        if (cut > 0 && cut < pkt.size()) pkt = pkt[0:cut - 1];
        foreach (pkt[i])
            send_item(FUNC_BYTE, {152'd0, pkt[i]}, i == pkt.size() - 1);
    endtask

    function automatic logic [127:0] pick_src(bit v6);
        logic [127:0] a;
        logic [127:0] flip;
        if (v6)
            a = (pool6.size() > 0 && $urandom_range(0, 4) != 0) ?
                pool6[$urandom_range(0, pool6.size() - 1)] : {rand64(), rand64()};
        else
            a = (pool4.size() > 0 && $urandom_range(0, 4) != 0) ?
                pool4[$urandom_range(0, pool4.size() - 1)] : {96'd0, $urandom};
        flip = {rand64(), rand64()} >> $urandom_range(v6 ? 0 : 96, 128);
        return a ^ flip;
    endfunction

    task automatic rand_packet();
        int          kind;
        int          ntags;
        logic [15:0] et;
        bit          v6;
        kind = $urandom_range(0, 19);
        ntags = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 2);
        v6 = 1'($urandom_range(0, 1));
        et = v6 ? ETH_IPV6 : ETH_IPV4;
        if (kind == 0)
            et = 16'($urandom);
        else if (kind == 1)
            et = $urandom_range(0, 1) ? ETH_VLAN : ETH_QINQ;
        if (kind == 2)
            send_packet(ntags, et, pick_src(v6), 0, $urandom_range(1, 60));
        else
            send_packet(ntags, et, pick_src(v6), $urandom_range(0, 12), 0);
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            int hold_cnt;
            int stall_cnt;
            bit hold_taken;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_cnt = 4000;
                m_axis_tready <= 1'b0;
            end
            else if (quiet)
                m_axis_tready <= 1'b1;
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_cnt = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = FUNC_BYTE;
        hold_req = 0;
        quiet = 0;
        items_sent = 0;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then clamped and aborted rules at the extremes
        send_packet(0, ETH_IPV4, 128'h0a000001, 0, 0);
        write_rule(1023, 1, 0, 255, '1, 64'h00000000c0a80000, 7);
        write_rule(0, 1, 0, 0, '0, '0, 1);
        write_rule(5, 1, 1, 128, '1, '1, 4);
        write_rule(6, 1, 1, 64, 64'hffffffffffffffff, '0, 3);
        write_rule(7, 1, 1, 200, 64'h2001_0db8_0000_0000, 64'h1, 2);
        send_packet(0, ETH_IPV4, 128'hc0a80000, 0, 0);
        send_packet(2, ETH_IPV6, '1, 0, 0);
        send_packet(1, ETH_IPV6, {64'hffffffffffffffff, 64'h5}, 3, 0);
        send_packet(3, ETH_IPV4, 128'hc0a80000, 0, 0);
        send_packet(0, ETH_IPV4, 128'hc0a80000, 0, 30);
        send_packet(0, 16'h1234, '0, 10, 0);
        send_packet(0, ETH_IPV4, '0, 0, 1);
        write_rule(1023, 0, 0, 32, '0, 64'hc0a80000, 3);
        send_packet(1, ETH_IPV4, 128'hc0a80000, 0, 0);

        while (items_sent < 1500 || board.pending.size() + board.verdicts_seen < 45)
        begin
            if (items_sent > 400 && items_sent < 460) hold_req = 1;
            if (items_sent > 800 && items_sent < 900 && board.pending.size() != 0)
            begin
                s_axis_tvalid <= 1'b0;
                while (board.pending.size() != 0) @(posedge clk);
            end
            if (items_sent > 1300) quiet = 1;
            if ($urandom_range(0, 2) == 0) rand_rule();
            else rand_packet();
        end
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/vipf_pkg.sv
rtl/vipf_parser.sv
rtl/vipf_cell.sv
rtl/vlan_ip_source_prefix_filter_core.sv
tb/sv/tb_vlan_ip_source_prefix_filter_core.sv
